// ===== rtl/kpl_pkg.sv =====
// Shared types, codes and constants of the keypad lock with stepper drive.
// No dependencies; every other file of the block refers to this package.
package kpl_pkg;

    // Field widths
    localparam int DIGIT_W   = 4;
    localparam int COIL_W    = 6;
    localparam int PWD_COUNT = 4;
    localparam int CFG_IDX_W = 2;

    // Defaults of the top-level parameters
    localparam int STEPS_PER_TURN_DEF = 32;
    localparam int CODE_LENGTH_DEF    = 4;

    // Key position of the hash key
    localparam logic [DIGIT_W-1:0] HASH_KEY = 4'd14;

    // Tick kinds
    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_MOTOR = 1'b1;

    // Entry sequencer
    typedef enum logic [1:0] {
        EP_IDLE,
        EP_BEEP,
        EP_HASH,
        EP_WAIT
    } entry_phase_t;

    // Stepper sequencer
    typedef enum logic [1:0] {
        MP_REST_LOCKED,
        MP_REST_UNLOCKED,
        MP_TURN_CW,
        MP_TURN_CCW
    } motor_phase_t;

    // Input request payload
    typedef struct packed {
        logic               opcode;
        logic               key_pressed;
        logic [DIGIT_W-1:0] key_code;
    } kpl_in_t;

    // Result payload
    typedef struct packed {
        logic              is_locked;
        logic [COIL_W-1:0] coil_pattern;
        logic              buzzer_enable;
        logic              red_led;
        logic              green_led;
        logic              blue_led;
        logic              white_led;
    } kpl_out_t;

    // Status from the entry sequencer (values after the current tick)
    typedef struct packed {
        logic locked;
        logic buzz;
        logic red;
        logic blue;
    } entry_status_t;

    // Full-step (two coils on) phase table
    function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            2'd0:    pat = 6'h36;
            2'd1:    pat = 6'h35;
            2'd2:    pat = 6'h39;
            2'd3:    pat = 6'h3A;
            default: pat = 6'h36;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/kpl_if.sv =====
// Valid/ready channel interfaces for the input and result requests.
// Depends on kpl_pkg for the payload types.
interface kpl_in_if;
    logic            valid;
    logic            ready;
    kpl_pkg::kpl_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kpl_out_if;
    logic             valid;
    logic             ready;
    kpl_pkg::kpl_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/keypad_lock_with_stepper_drive.sv =====
// Top level of the keypad lock with stepper drive: channels, result register.
// Depends on kpl_pkg, kpl_if, kpl_entry and kpl_motor.
//
// Usage:
//   in_ch carries one tick per request: opcode 0 is a keypad tick with the
//   debounced key sample, opcode 1 is a stepper tick. Every accepted request
//   yields exactly one result on out_ch: lock flag, coil pattern, buzzer and
//   the four LEDs as they stand after that tick.
//   Password digits are written through cfg_we / cfg_index / cfg_data while
//   no request is in flight.
// Timing:
//   The result is in the output register on the cycle after acceptance.
//   Throughput is one request per cycle unless out_ch stalls; the tick's
//   state update is a single level of next-state logic in the entry and
//   stepper sequencers, loaded in the same edge as the output register.
// Reset:
//   rst_n clears to locked, idle entry, stepper at rest, coils off, LEDs and
//   buzzer off, password digits zero; no result is pending.
// Stall:
//   While a result waits and out_ch.ready is low, in_ch.ready is low; a new
//   request is taken in the same cycle the waiting result is taken.
module keypad_lock_with_stepper_drive #(
    parameter int STEPS_PER_TURN = kpl_pkg::STEPS_PER_TURN_DEF,
    parameter int CODE_LENGTH    = kpl_pkg::CODE_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kpl_pkg::DIGIT_W-1:0]    cfg_data,
    kpl_in_if.sink                         in_ch,
    kpl_out_if.source                      out_ch
);

    kpl_pkg::entry_status_t     entry_st;
    kpl_pkg::kpl_out_t          out_data_reg, out_data_next;
    logic                       out_valid_reg;
    logic                       in_fire;
    logic                       key_tick, step_tick;
    logic [kpl_pkg::COIL_W-1:0] coil;

    // Input handshake: taken whenever the result register is free or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign key_tick    = in_fire && (in_ch.data.opcode == kpl_pkg::OP_KEY);
    assign step_tick   = in_fire && (in_ch.data.opcode == kpl_pkg::OP_MOTOR);

    kpl_entry #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_entry (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .key_tick    (key_tick),
        .key_pressed (in_ch.data.key_pressed),
        .key_code    (in_ch.data.key_code),
        .status      (entry_st)
    );

    kpl_motor #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_motor (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_tick (step_tick),
        .locked    (entry_st.locked),
        .coil      (coil)
    );

    // Result assembly
    always_comb
    begin
        out_data_next.is_locked     = entry_st.locked;
        out_data_next.coil_pattern  = coil;
        out_data_next.buzzer_enable = entry_st.buzz;
        out_data_next.red_led       = entry_st.red;
        out_data_next.green_led     = !entry_st.locked;
        out_data_next.blue_led      = entry_st.blue;
        out_data_next.white_led     = coil[0];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Checks
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_ch.valid)
        else $error("accepted request produced no result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty result register");

    a_green_vs_lock: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.data.green_led != out_ch.data.is_locked))
        else $error("green LED disagrees with lock flag");

endmodule

// ===== rtl/kpl_entry.sv =====
// Key entry sequencer: key store, password registers, code check, lock flag, LEDs.
// Depends on kpl_pkg.
module kpl_entry #(
    parameter int CODE_LENGTH = kpl_pkg::CODE_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kpl_pkg::DIGIT_W-1:0]    cfg_data,
    input  logic                           key_tick,
    input  logic                           key_pressed,
    input  logic [kpl_pkg::DIGIT_W-1:0]    key_code,
    output kpl_pkg::entry_status_t         status
);

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    kpl_pkg::entry_phase_t phase_reg, phase_next;

    logic [kpl_pkg::DIGIT_W-1:0] keys_reg   [CODE_LENGTH];
    logic [kpl_pkg::DIGIT_W-1:0] keys_next  [CODE_LENGTH];
    logic [kpl_pkg::DIGIT_W-1:0] keys_store [CODE_LENGTH];
    logic [kpl_pkg::DIGIT_W-1:0] pwd_reg    [kpl_pkg::PWD_COUNT];

    logic [CNT_W-1:0] count_reg, count_next, count_inc;
    logic             lock_reg, lock_next;
    logic             red_reg, red_next;
    logic             blue_reg, blue_next;
    logic             buzz_reg, buzz_next;
    logic             mismatch;

    // Password registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kpl_pkg::PWD_COUNT; i++)
            begin
                pwd_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            pwd_reg[cfg_index] <= cfg_data;
        end
    end

    // Entry with the new key in place, and its compare against the password
    always_comb
    begin
        keys_store = keys_reg;
        keys_store[count_reg[IDX_W-1:0]] = key_code;
        mismatch = 1'b0;
        for (int k = 0; k < CODE_LENGTH; k++)
        begin
            if (keys_store[k] != pwd_reg[k % kpl_pkg::PWD_COUNT])
            begin
                mismatch = 1'b1;
            end
        end
    end

    assign count_inc = count_reg + CNT_W'(1);

    // Next state of the entry sequencer
    always_comb
    begin
        phase_next = phase_reg;
        if (key_tick)
        begin
            case (phase_reg)
                kpl_pkg::EP_IDLE:
                begin
                    if (key_pressed)
                    begin
                        phase_next = (key_code == kpl_pkg::HASH_KEY) ? kpl_pkg::EP_HASH
                                                                      : kpl_pkg::EP_BEEP;
                    end
                end
                kpl_pkg::EP_BEEP: phase_next = kpl_pkg::EP_WAIT;
                kpl_pkg::EP_HASH: phase_next = kpl_pkg::EP_WAIT;
                kpl_pkg::EP_WAIT:
                begin
                    if (!key_pressed)
                    begin
                        phase_next = kpl_pkg::EP_IDLE;
                    end
                end
                default: phase_next = kpl_pkg::EP_IDLE;
            endcase
        end
    end

    // Key store, lock flag and indicator bits
    always_comb
    begin
        keys_next  = keys_reg;
        count_next = count_reg;
        lock_next  = lock_reg;
        red_next   = red_reg;
        blue_next  = blue_reg;
        buzz_next  = buzz_reg;
        if (key_tick)
        begin
            case (phase_reg)
                kpl_pkg::EP_IDLE:
                begin
                    if (!key_pressed)
                    begin
                        red_next  = 1'b0;
                        blue_next = 1'b0;
                    end
                    else if (key_code == kpl_pkg::HASH_KEY)
                    begin
                        red_next = 1'b1;
                    end
                    else if (count_inc >= CNT_W'(CODE_LENGTH))
                    begin
                        // full code entered: check and clear
                        for (int i = 0; i < CODE_LENGTH; i++)
                        begin
                            keys_next[i] = '0;
                        end
                        count_next = '0;
                        lock_next  = mismatch;
                        if (!mismatch)
                        begin
                            red_next = 1'b0;
                        end
                    end
                    else
                    begin
                        keys_next  = keys_store;
                        count_next = count_inc;
                    end
                end
                kpl_pkg::EP_BEEP:
                begin
                    buzz_next = 1'b1;
                    blue_next = 1'b1;
                end
                kpl_pkg::EP_HASH:
                begin
                    buzz_next = 1'b1;
                    blue_next = 1'b1;
                    lock_next = 1'b1;
                    for (int i = 0; i < CODE_LENGTH; i++)
                    begin
                        keys_next[i] = '0;
                    end
                    count_next = '0;
                end
                default:
                begin
                    buzz_next = 1'b0;
                    if (key_pressed)
                    begin
                        blue_next = 1'b1;
                    end
                    else
                    begin
                        red_next  = 1'b0;
                        blue_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kpl_pkg::EP_IDLE;
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                keys_reg[i] <= '0;
            end
            count_reg <= '0;
            lock_reg  <= 1'b1;
            red_reg   <= 1'b0;
            blue_reg  <= 1'b0;
            buzz_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            keys_reg  <= keys_next;
            count_reg <= count_next;
            lock_reg  <= lock_next;
            red_reg   <= red_next;
            blue_reg  <= blue_next;
            buzz_reg  <= buzz_next;
        end
    end

    assign status.locked = lock_next;
    assign status.buzz   = buzz_next;
    assign status.red    = red_next;
    assign status.blue   = blue_next;

endmodule

// ===== rtl/kpl_motor.sv =====
// Stepper sequencer: rest/turn phases, step counter, full-step coil pattern.
// Depends on kpl_pkg.
module kpl_motor #(
    parameter int STEPS_PER_TURN = kpl_pkg::STEPS_PER_TURN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_tick,
    input  logic                        locked,
    output logic [kpl_pkg::COIL_W-1:0]  coil
);

    localparam int SC_W = $clog2(STEPS_PER_TURN + 1);

    kpl_pkg::motor_phase_t mp_reg, mp_next;

    logic [SC_W-1:0] sc_reg, sc_next;
    logic [1:0]      ph_reg, ph_next;
    logic            driven_reg, driven_next;
    logic            turning_now, turning_next, turn_done;

    assign turning_now  = (mp_reg == kpl_pkg::MP_TURN_CW) || (mp_reg == kpl_pkg::MP_TURN_CCW);
    assign turning_next = (mp_next == kpl_pkg::MP_TURN_CW) || (mp_next == kpl_pkg::MP_TURN_CCW);
    assign turn_done    = (sc_reg >= SC_W'(STEPS_PER_TURN));

    // Next state of the stepper sequencer
    always_comb
    begin
        mp_next = mp_reg;
        if (step_tick)
        begin
            case (mp_reg)
                kpl_pkg::MP_REST_LOCKED:
                begin
                    if (!locked)
                    begin
                        mp_next = kpl_pkg::MP_TURN_CW;
                    end
                end
                kpl_pkg::MP_REST_UNLOCKED:
                begin
                    if (locked)
                    begin
                        mp_next = kpl_pkg::MP_TURN_CCW;
                    end
                end
                kpl_pkg::MP_TURN_CW:
                begin
                    if (turn_done)
                    begin
                        mp_next = kpl_pkg::MP_REST_UNLOCKED;
                    end
                end
                default:
                begin
                    if (turn_done)
                    begin
                        mp_next = kpl_pkg::MP_REST_LOCKED;
                    end
                end
            endcase
        end
    end

    // Step counter, phase pointer and drive flag
    always_comb
    begin
        sc_next     = sc_reg;
        ph_next     = ph_reg;
        driven_next = driven_reg;
        if (step_tick)
        begin
            if (turning_next)
            begin
                ph_next     = (mp_next == kpl_pkg::MP_TURN_CW) ? ph_reg + 2'd1 : ph_reg + 2'd3;
                driven_next = 1'b1;
                sc_next     = sc_reg + SC_W'(1);
            end
            else if (turning_now)
            begin
                // end of a turn: no step, counter cleared
                sc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg     <= kpl_pkg::MP_REST_LOCKED;
            sc_reg     <= '0;
            ph_reg     <= 2'd0;
            driven_reg <= 1'b0;
        end
        else
        begin
            mp_reg     <= mp_next;
            sc_reg     <= sc_next;
            ph_reg     <= ph_next;
            driven_reg <= driven_next;
        end
    end

    assign coil = driven_next ? kpl_pkg::coil_of(ph_next) : '0;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of keypad_lock_with_stepper_drive: keypad and stepper ticks with
// random stalls on both channels, checked against a cycle-free predictor of the lock.
// Depends on kpl_pkg, kpl_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;

    localparam int DIGIT_W        = kpl_pkg::DIGIT_W;
    localparam int COIL_W         = kpl_pkg::COIL_W;
    localparam int CFG_IDX_W      = kpl_pkg::CFG_IDX_W;
    localparam int PWD_COUNT      = kpl_pkg::PWD_COUNT;
    localparam int STEPS_PER_TURN = kpl_pkg::STEPS_PER_TURN_DEF;
    localparam int CODE_LENGTH    = kpl_pkg::CODE_LENGTH_DEF;
    localparam int MAX_KEYS       = 8;
    localparam int PHASES         = 5;
    localparam int PHASE_REQUESTS = 130;
    localparam int LONG_HOLD      = 80;
    localparam int STALL_LIMIT    = 2000;

    // Lock predictor and result checker
    class lock_scoreboard;
        logic [DIGIT_W-1:0]     pwd [PWD_COUNT];
        kpl_pkg::entry_phase_t  ep;
        logic [DIGIT_W-1:0]     keys [MAX_KEYS];
        int unsigned            key_cnt;
        logic                   locked;
        kpl_pkg::motor_phase_t  mp;
        logic [5:0]             steps;
        logic [1:0]             phase;
        logic                   red;
        logic                   blue;
        logic                   buzz;
        logic                   driven;
        kpl_pkg::kpl_out_t      pending_status [$];
        int unsigned            results_seen;
        int unsigned            errors;

        function new();
            foreach (pwd[i]) pwd[i] = '0;
            clear_entry();
            ep           = kpl_pkg::EP_IDLE;
            locked       = 1'b1;
            mp           = kpl_pkg::MP_REST_LOCKED;
            steps        = '0;
            phase        = '0;
            red          = 1'b0;
            blue         = 1'b0;
            buzz         = 1'b0;
            driven       = 1'b0;
            results_seen = 0;
            errors       = 0;
        endfunction

        function void clear_entry();
            key_cnt = 0;
            foreach (keys[i]) keys[i] = '0;
        endfunction

        function void lock_and_clear();
            locked = 1'b1;
            clear_entry();
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        // Entry compared digit by digit; the fifth key and on reuse the digits again
        function void compare_code();
            for (int k = 0; k < CODE_LENGTH && k < MAX_KEYS; k++)
            begin
                if (keys[k] != pwd[k % PWD_COUNT])
                begin
                    lock_and_clear();
                    return;
                end
            end
            locked = 1'b0;
            clear_entry();
            red = 1'b0;
        endfunction

        function void key_tick(logic pressed, logic [DIGIT_W-1:0] code);
            case (ep)
                kpl_pkg::EP_IDLE:
                begin
                    if (!pressed)
                    begin
                        red  = 1'b0;
                        blue = 1'b0;
                    end
                    else if (code == kpl_pkg::HASH_KEY)
                    begin
                        ep  = kpl_pkg::EP_HASH;
                        red = 1'b1;
                    end
                    else
                    begin
                        ep = kpl_pkg::EP_BEEP;
                        if (key_cnt < MAX_KEYS)
                            keys[key_cnt] = code;
                        key_cnt++;
                        if (key_cnt >= CODE_LENGTH)
                            compare_code();
                    end
                end
                kpl_pkg::EP_BEEP:
                begin
                    buzz = 1'b1;
                    blue = 1'b1;
                    ep   = kpl_pkg::EP_WAIT;
                end
                kpl_pkg::EP_HASH:
                begin
                    buzz = 1'b1;
                    blue = 1'b1;
                    lock_and_clear();
                    ep   = kpl_pkg::EP_WAIT;
                end
                default:
                begin
                    buzz = 1'b0;
                    if (pressed)
                        blue = 1'b1;
                    else
                    begin
                        ep   = kpl_pkg::EP_IDLE;
                        red  = 1'b0;
                        blue = 1'b0;
                    end
                end
            endcase
        endfunction

        // A turn always finishes before the opposite one can start
        function void motor_tick();
            case (mp)
                kpl_pkg::MP_REST_LOCKED:
                    if (!locked)
                        mp = kpl_pkg::MP_TURN_CW;
                kpl_pkg::MP_REST_UNLOCKED:
                    if (locked)
                        mp = kpl_pkg::MP_TURN_CCW;
                default:
                    if (steps >= STEPS_PER_TURN)
                    begin
                        steps = '0;
                        mp    = (mp == kpl_pkg::MP_TURN_CW) ? kpl_pkg::MP_REST_UNLOCKED
                                                            : kpl_pkg::MP_REST_LOCKED;
                    end
            endcase
            if (mp == kpl_pkg::MP_TURN_CW || mp == kpl_pkg::MP_TURN_CCW)
            begin
                phase  = (mp == kpl_pkg::MP_TURN_CW) ? phase + 2'd1 : phase - 2'd1;
                driven = 1'b1;
                steps  = steps + 6'd1;
            end
        endfunction

        // Accepted request: advance the predictor and queue the status it leads to
        function void note_request(kpl_pkg::kpl_in_t req);
            kpl_pkg::kpl_out_t  res;
            logic [COIL_W-1:0]  coil;
            if (req.opcode == kpl_pkg::OP_KEY)
                key_tick(req.key_pressed, req.key_code);
            else
                motor_tick();
            coil = '0;
            if (driven)
            begin
                case (phase)
                    2'd0:    coil = 6'h36;
                    2'd1:    coil = 6'h35;
                    2'd2:    coil = 6'h39;
                    default: coil = 6'h3A;
                endcase
            end
            res.is_locked     = locked;
            res.coil_pattern  = coil;
            res.buzzer_enable = buzz;
            res.red_led       = red;
            res.green_led     = ~locked;
            res.blue_led      = blue;
            res.white_led     = coil[0];
            pending_status.push_back(res);
        endfunction

        task report_mismatch(string what, logic [COIL_W-1:0] got, logic [COIL_W-1:0] want);
            errors++;
            $display("[%0t] MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
                     $realtime, results_seen, what, got, want);
        endtask

        task compare_field(string what, logic [COIL_W-1:0] got, logic [COIL_W-1:0] want);
            if (got !== want)
                report_mismatch(what, got, want);
        endtask

        task check_result(kpl_pkg::kpl_out_t got);
            kpl_pkg::kpl_out_t want;
            results_seen++;
            if (pending_status.size() == 0)
            begin
                report_mismatch("result with no request", '0, '0);
                return;
            end
            want = pending_status.pop_front();
            compare_field("is_locked", COIL_W'(got.is_locked), COIL_W'(want.is_locked));
            compare_field("coil_pattern", got.coil_pattern, want.coil_pattern);
            compare_field("buzzer_enable", COIL_W'(got.buzzer_enable),
                          COIL_W'(want.buzzer_enable));
            compare_field("red_led", COIL_W'(got.red_led), COIL_W'(want.red_led));
            compare_field("green_led", COIL_W'(got.green_led), COIL_W'(want.green_led));
            compare_field("blue_led", COIL_W'(got.blue_led), COIL_W'(want.blue_led));
            compare_field("white_led", COIL_W'(got.white_led), COIL_W'(want.white_led));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIGIT_W-1:0]   cfg_data;

    kpl_in_if  in_ch ();
    kpl_out_if out_ch ();

    lock_scoreboard sb = new();

    bit          idling;
    bit          hold_off;
    int unsigned sent;
    int unsigned stall_cycles = 0;

    keypad_lock_with_stepper_drive u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #1 clk = ~clk;

    // One tick request; optional idle burst before it, then hold until taken
    task automatic send_tick(input logic op, input logic pressed, input logic [DIGIT_W-1:0] code);
        kpl_pkg::kpl_in_t req;
        req.opcode      = op;
        req.key_pressed = pressed;
        req.key_code    = code;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= req;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(req);
        sent++;
    endtask

    // Press, beep tick with a stray sample, some held ticks, release
    task automatic press_key(input logic [DIGIT_W-1:0] code, input int holds);
        send_tick(kpl_pkg::OP_KEY, 1'b1, code);
        send_tick(kpl_pkg::OP_KEY, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        repeat (holds) send_tick(kpl_pkg::OP_KEY, 1'b1, 4'($urandom_range(0, 15)));
        send_tick(kpl_pkg::OP_KEY, 1'b0, 4'($urandom_range(0, 15)));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Only called with the block idle
    task automatic write_password(input logic [4*DIGIT_W-1:0] digits);
        for (int i = 0; i < PWD_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= digits[i*DIGIT_W +: DIGIT_W];
            @(posedge clk);
            sb.pwd[i] = digits[i*DIGIT_W +: DIGIT_W];
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed code entries and motor runs, some stray keys and noise
    task automatic random_action();
        int unsigned pick;
        logic [DIGIT_W-1:0] digit;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            if ($urandom_range(0, 1) == 1)
                press_key(kpl_pkg::HASH_KEY, $urandom_range(0, 3));
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                digit = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                    : sb.pwd[i % PWD_COUNT];
                press_key(digit, $urandom_range(0, 3));
            end
        end
        else if (pick < 40)
            press_key(kpl_pkg::HASH_KEY, $urandom_range(0, 3));
        else if (pick < 50)
            press_key(4'($urandom_range(0, 15)), $urandom_range(0, 3));
        else if (pick < 85)
            repeat ($urandom_range(1, 40))
                send_tick(kpl_pkg::OP_MOTOR, 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)));
        else
            repeat ($urandom_range(1, 5))
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)));
    endtask

    // Result side: random stall bursts, one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.data);
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Main sequence
    initial
    begin
        logic [4*DIGIT_W-1:0] digits;
        int unsigned          target;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        idling      = 1'b0;
        hold_off    = 1'b0;
        sent        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle samples, rest motor, unlock with the reset code, hash, top key
        send_tick(kpl_pkg::OP_KEY, 1'b0, 4'hF);
        send_tick(kpl_pkg::OP_MOTOR, 1'b0, 4'h0);
        repeat (CODE_LENGTH) press_key(4'h0, 0);
        send_tick(kpl_pkg::OP_MOTOR, 1'b1, 4'hF);
        press_key(kpl_pkg::HASH_KEY, 1);
        press_key(4'hF, 0);
        send_tick(kpl_pkg::OP_KEY, 1'b0, 4'h0);

        // Random phases, each under its own password
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0:       digits = 16'h0000;
                1:       digits = 16'hFFFF;
                2:       digits = 16'h5A0F;
                default: digits = 16'($urandom);
            endcase
            write_password(digits);
            idling = (p < PHASES - 1);
            if (p == 2)
                hold_off = 1'b1;
            target = sent + PHASE_REQUESTS;
            while (sent < target)
                random_action();
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
